[sv/ptw_pkg.sv]
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types and constants of the four-level page table walker: field
// widths, operation and status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    localparam int VA_W      = 48;
    localparam int PA_W      = 52;
    localparam int FLAG_W    = 12;
    localparam int ENTRY_W   = 64;
    localparam int PG_W      = 40;
    localparam int IDX_W     = 9;
    localparam int OFF_W     = 12;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;

    localparam logic [KIND_W-1:0] KIND_MAP   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UNMAP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_XLATE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_MAPPED    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OUT_OF_TABLES = 2'd2;

    localparam logic [OFF_W-1:0] LINK_FLAGS = 12'h007;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LATCH,
        S_EVAL,
        S_ZERO,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                accept;
        logic                clr_step;
        logic                latch;
        logic                descend;
        logic                alloc;
        logic                zero_step;
        logic                link_wr;
        logic                leaf_wr;
        logic                set_st;
        logic [STATUS_W-1:0] st;
        logic                res_ok;
        logic                load_out;
    } t_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              lvl_zero;
        logic              present;
        logic              off_ok;
        logic              tables_left;
        logic              clr_last;
        logic              zero_last;
        logic              out_free;
    } t_stat;

endpackage

`default_nettype wire

[sv/ptw_ram.sv]
// ----------------------------------------------------------------------------
// ptw_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/ptw_ctrl.sv]
// ----------------------------------------------------------------------------
// ptw_ctrl
// Walk controller: sequences the reset clearing pass, up to four table reads,
// table allocation with its clearing sweep, the leaf write and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ctrl
    import ptw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_valid,
    output logic       o_s_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_valid) n_state = S_READ;
            end
            S_READ:  n_state = S_LATCH;
            S_LATCH: n_state = S_EVAL;
            S_EVAL: begin
                if (i_stat.lvl_zero) begin
                    n_state = S_DONE;
                end else if (!i_stat.present) begin
                    if (i_stat.kind == KIND_MAP && i_stat.tables_left) begin
                        n_state = S_ZERO;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_stat.off_ok) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ZERO: begin
                if (i_stat.zero_last) n_state = S_LINK;
            end
            S_LINK: n_state = S_READ;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
        if (r_state == S_IDLE && i_s_valid && i_stat.kind != KIND_MAP
            && i_stat.kind != KIND_UNMAP && i_stat.kind != KIND_XLATE) begin
            n_state = S_DONE;
        end
    end

    always_comb begin
        o_cmd     = '0;
        o_cmd.st  = ST_OK;
        o_s_ready = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_s_ready    = 1'b1;
                o_cmd.accept = i_s_valid;
            end
            S_READ:  o_cmd = '0;
            S_LATCH: o_cmd.latch = 1'b1;
            S_EVAL: begin
                o_cmd.set_st = 1'b1;
                if (i_stat.lvl_zero) begin
                    case (i_stat.kind)
                        KIND_MAP: begin
                            o_cmd.leaf_wr = 1'b1;
                            o_cmd.st      = ST_OK;
                        end
                        KIND_UNMAP: begin
                            o_cmd.leaf_wr = 1'b1;
                            o_cmd.st      = i_stat.present ? ST_OK : ST_NOT_MAPPED;
                        end
                        KIND_XLATE: begin
                            o_cmd.res_ok = i_stat.present;
                            o_cmd.st     = i_stat.present ? ST_OK : ST_NOT_MAPPED;
                        end
                        default: o_cmd.st = ST_OK;
                    endcase
                end else if (!i_stat.present) begin
                    if (i_stat.kind == KIND_MAP) begin
                        if (i_stat.tables_left) begin
                            o_cmd.set_st = 1'b0;
                            o_cmd.alloc  = 1'b1;
                        end else begin
                            o_cmd.st = ST_OUT_OF_TABLES;
                        end
                    end else begin
                        o_cmd.st = ST_NOT_MAPPED;
                    end
                end else if (i_stat.off_ok) begin
                    o_cmd.set_st  = 1'b0;
                    o_cmd.descend = 1'b1;
                end else begin
                    o_cmd.st = (i_stat.kind == KIND_MAP) ? ST_OUT_OF_TABLES
                                                         : ST_NOT_MAPPED;
                end
            end
            S_ZERO: o_cmd.zero_step = 1'b1;
            S_LINK: o_cmd.link_wr = 1'b1;
            S_DONE: o_cmd.load_out = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

[sv/ptw_dpath.sv]
// ----------------------------------------------------------------------------
// ptw_dpath
// Walk datapath: table store, item and walk registers, frame allocator,
// link decode, store write select and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_dpath
    import ptw_pkg::*;
#(
    parameter int NUM_TABLES = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_stat                    o_stat,
    input  wire logic                i_cfg_valid,
    input  wire logic [PA_W-1:0]     i_cfg_data,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [VA_W-1:0]     i_va,
    input  wire logic [PA_W-1:0]     i_pa,
    input  wire logic [FLAG_W-1:0]   i_flags,
    input  wire logic                i_m_ready,
    output logic                     o_m_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [PA_W-1:0]          o_phys
);

    localparam int FW    = $clog2(NUM_TABLES);
    localparam int NW    = $clog2(NUM_TABLES + 1);
    localparam int DEPTH = NUM_TABLES * 512;
    localparam int AW    = FW + IDX_W;

    logic [PA_W-1:0]     r_base;
    logic [KIND_W-1:0]   r_kind;
    logic [VA_W-1:0]     r_va;
    logic [PA_W-1:0]     r_pa;
    logic [FLAG_W-1:0]   r_flags;
    logic [1:0]          r_level;
    logic [FW-1:0]       r_cur;
    logic [ENTRY_W-1:0]  r_entry;
    logic [PG_W-1:0]     r_off;
    logic [FW-1:0]       r_nf;
    logic [NW-1:0]       r_next_free;
    logic [AW-1:0]       r_clr;
    logic [STATUS_W-1:0] r_status;
    logic [PA_W-1:0]     r_result;
    logic                r_m_valid;
    logic [STATUS_W-1:0] r_m_status;
    logic [PA_W-1:0]     r_m_phys;

    logic [IDX_W-1:0]    slice;
    logic [AW-1:0]       slot;
    logic [PG_W-1:0]     link_pg;
    logic [ENTRY_W-1:0]  rd_data;
    logic                we;
    logic [AW-1:0]       waddr;
    logic [ENTRY_W-1:0]  wdata;

    always_comb begin
        case (r_level)
            2'd3:    slice = r_va[47:39];
            2'd2:    slice = r_va[38:30];
            2'd1:    slice = r_va[29:21];
            default: slice = r_va[20:12];
        endcase
    end

    assign slot    = {r_cur, slice};
    assign link_pg = r_base[PA_W-1:OFF_W] + PG_W'(r_nf);

    always_comb begin
        we    = 1'b0;
        waddr = slot;
        wdata = '0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_clr;
        end else if (i_cmd.zero_step) begin
            we    = 1'b1;
            waddr = {r_nf, r_clr[IDX_W-1:0]};
        end else if (i_cmd.link_wr) begin
            we    = 1'b1;
            wdata = {{(ENTRY_W - PA_W){1'b0}}, link_pg, LINK_FLAGS};
        end else if (i_cmd.leaf_wr) begin
            we = 1'b1;
            if (r_kind == KIND_MAP) begin
                wdata = {{(ENTRY_W - PA_W){1'b0}},
                         r_pa | {{(PA_W - FLAG_W){1'b0}}, r_flags}};
            end
        end
    end

    ptw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (slot),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_level     <= '0;
            r_cur       <= '0;
            r_next_free <= NW'(1);
            r_clr       <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_level <= 2'd3;
                r_cur   <= '0;
            end
            if (i_cmd.descend) begin
                r_level <= r_level - 2'd1;
                r_cur   <= r_off[FW-1:0];
            end
            if (i_cmd.link_wr) begin
                r_level <= r_level - 2'd1;
                r_cur   <= r_nf;
            end
            if (i_cmd.alloc) begin
                r_next_free <= r_next_free + NW'(1);
                r_clr       <= '0;
            end
            if (i_cmd.clr_step || i_cmd.zero_step) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_kind;
            r_va     <= i_va;
            r_pa     <= i_pa;
            r_flags  <= i_flags;
            r_status <= ST_OK;
            r_result <= '0;
        end
        if (i_cmd.latch) begin
            r_entry <= rd_data;
            r_off   <= rd_data[PA_W-1:OFF_W] - r_base[PA_W-1:OFF_W];
        end
        if (i_cmd.alloc) begin
            r_nf <= r_next_free[FW-1:0];
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
        if (i_cmd.res_ok) begin
            r_result <= {r_entry[PA_W-1:OFF_W], r_va[OFF_W-1:0]};
        end
        if (i_cmd.load_out) begin
            r_m_status <= r_status;
            r_m_phys   <= r_result;
        end
    end

    always_comb begin
        o_stat.kind        = i_cmd.accept ? i_kind : r_kind;
        o_stat.lvl_zero    = (r_level == 2'd0);
        o_stat.present     = r_entry[0];
        o_stat.off_ok      = (r_off < PG_W'(NUM_TABLES));
        o_stat.tables_left = (r_next_free < NW'(NUM_TABLES));
        o_stat.clr_last    = (r_clr == AW'(DEPTH - 1));
        o_stat.zero_last   = (r_clr[IDX_W-1:0] == {IDX_W{1'b1}});
        o_stat.out_free    = !r_m_valid || i_m_ready;
    end

    assign o_m_valid = r_m_valid;
    assign o_status  = r_m_status;
    assign o_phys    = r_m_phys;

endmodule

`default_nettype wire

[sv/four_level_page_table_walker_core.sv]
// Each table level passes through the READ, LATCH and EVAL states via the registered
// store read port; a walk that stops early ends sooner. Map adds, per new table, a
// 512-entry clearing sweep and the link write. The core takes one item at a time;
// the next beat is taken once the result is in the output register. After reset,
// tready stays low while the table store of NUM_TABLES*512 entries is cleared one
// entry per cycle.
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Map, unmap and translate 4 KB pages through a four-level radix page table
// held in an internal store of table frames with a bump frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_core
    import ptw_pkg::*;
#(
    parameter int NUM_TABLES = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [PA_W-1:0]      i_cfg_data,      // table_base
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,    // virt_addr, phys_addr, entry_flags
    input  wire logic [KIND_W-1:0]    s_axis_tuser,    // kind
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,    // phys_result, zero pad
    output logic [STATUS_W-1:0]       m_axis_tuser     // status
);

    t_cmd            cmd;
    t_stat           stat;
    logic [PA_W-1:0] phys;

    assign o_cfg_ready = 1'b1;

    ptw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    ptw_dpath #(
        .NUM_TABLES (NUM_TABLES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_kind      (s_axis_tuser),
        .i_va        (s_axis_tdata[VA_W-1:0]),
        .i_pa        (s_axis_tdata[VA_W+PA_W-1:VA_W]),
        .i_flags     (s_axis_tdata[S_TDATA_W-1:VA_W+PA_W]),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_status    (m_axis_tuser),
        .o_phys      (phys)
    );

    assign m_axis_tdata = {{(M_TDATA_W - PA_W){1'b0}}, phys};

endmodule

`default_nettype wire
